// File: rtl/kesd_pkg.sv
package kesd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PC,
    ST_ESC,
    ST_CSI,
    ST_DIGIT,
    ST_SWALLOW
  } seq_state_t;

  localparam logic       REQ_BYTE = 1'b0;
  localparam logic       REQ_TICK = 1'b1;

  localparam logic [2:0] KIND_CHAR  = 3'd0;
  localparam logic [2:0] KIND_NAMED = 3'd1;
  localparam logic [2:0] KIND_FKEY  = 3'd2;
  localparam logic [2:0] KIND_BEEP  = 3'd3;
  localparam logic [2:0] KIND_INTR  = 3'd4;

  localparam logic [3:0] NK_UP     = 4'd0;
  localparam logic [3:0] NK_DOWN   = 4'd1;
  localparam logic [3:0] NK_LEFT   = 4'd2;
  localparam logic [3:0] NK_RIGHT  = 4'd3;
  localparam logic [3:0] NK_HOME   = 4'd4;
  localparam logic [3:0] NK_END    = 4'd5;
  localparam logic [3:0] NK_PGUP   = 4'd6;
  localparam logic [3:0] NK_PGDOWN = 4'd7;
  localparam logic [3:0] NK_BKTAB  = 4'd8;

  // pending key kind while a trailing byte is swallowed
  localparam logic [1:0] PK_NONE  = 2'd0;
  localparam logic [1:0] PK_NAMED = 2'd1;
  localparam logic [1:0] PK_FKEY  = 2'd2;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_LF    = 8'h0a;
  localparam logic [7:0]  CH_ESC   = 8'h1b;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2;
  localparam logic [15:0] GAP_MAX  = 16'hffff;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_value;
    logic [3:0] named_key;
    logic [3:0] fkey_number;
  } key_res_t;

  // one queued input item: up to two results, the second always a plain char
  typedef struct packed {
    logic       two;
    key_res_t   first;
    logic [7:0] second_char;
  } out_rec_t;

  function automatic key_res_t mk_char(input logic [7:0] c);
    key_res_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.char_value = c;
    return r;
  endfunction

  function automatic key_res_t mk_named(input logic [3:0] nk);
    key_res_t r;
    r = '0;
    r.kind = KIND_NAMED;
    r.named_key = nk;
    return r;
  endfunction

  function automatic key_res_t mk_fkey(input logic [3:0] n);
    key_res_t r;
    r = '0;
    r.kind = KIND_FKEY;
    r.fkey_number = n;
    return r;
  endfunction

  function automatic key_res_t mk_kind(input logic [2:0] k);
    key_res_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

endpackage

// File: rtl/key_escape_sequence_decoder.sv
// Keyboard escape decoder. Each input word is either a raw key byte (tuser 0) or
// a timer tick (tuser 1); results come out as words with the kind in tuser and
// tlast on the final result of an input word. An input word can be accepted
// every clock while input ready is high; it is registered, decoded against the
// sequence state in the next cycle and written into a four-entry result queue,
// whose head is offered on the output. A byte that follows a lone ESC gives two
// results, the ESC and then the byte, from one queue entry. Input ready drops
// only when the result queue plus the word in decode would fill it. Timeout
// takes effect on the tick that brings the gap count up to timeout_ticks (zero
// acts as one).
module key_escape_sequence_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,   // timeout_ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // key_byte
  input  logic        s_tuser,    // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // char_value[7:0], named_key[11:8], fkey_number[15:12]
  output logic [2:0]  m_tuser,    // result_kind
  output logic        m_tlast     // last_of_run
);
  import kesd_pkg::*;

  typedef struct packed {
    logic       hold;     // swallow one more byte, then give pending key
    logic [3:0] code;
    key_res_t   res;
  } final_t;

  function automatic final_t body_final(input logic [8:0] v);
    final_t f;
    f = '0;
    unique case (v)
      9'h000: f.res = mk_named(NK_END);
      9'h041: f.res = mk_named(NK_UP);
      9'h042: f.res = mk_named(NK_DOWN);
      9'h043: f.res = mk_named(NK_RIGHT);
      9'h044: f.res = mk_named(NK_LEFT);
      9'h036: begin f.hold = 1'b1; f.code = NK_PGDOWN; end
      9'h033: begin f.hold = 1'b1; f.code = NK_PGUP; end
      9'h032: begin f.hold = 1'b1; f.code = NK_HOME; end
      9'h035: begin f.hold = 1'b1; f.code = NK_END; end
      default: f.res = mk_kind(KIND_BEEP);
    endcase
    return f;
  endfunction

  logic [15:0] timeout_ticks;
  seq_state_t  state, state_next;
  logic [15:0] gap_count, gap_count_next;
  logic        lead_two, lead_two_next;
  logic [1:0]  pend_kind, pend_kind_next;
  logic [3:0]  pend_code, pend_code_next;

  logic        in_valid;
  logic        in_type;
  logic [7:0]  in_byte;

  out_rec_t    q [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;
  logic        sub;

  logic        push, pop;
  out_rec_t    rec;
  final_t      fin;
  logic [8:0]  dv;
  logic [15:0] limit, gap_inc;
  key_res_t    pend_res;
  out_rec_t    head;

  assign s_tready = ({1'b0, count} + {3'b000, in_valid}) <= 4'd3;

  assign limit   = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
  assign gap_inc = (gap_count < GAP_MAX) ? gap_count + 16'd1 : gap_count;
  assign pend_res = (pend_kind == PK_FKEY) ? mk_fkey(pend_code) : mk_named(pend_code);

  always_comb begin
    state_next     = state;
    gap_count_next = gap_count;
    lead_two_next  = lead_two;
    pend_kind_next = pend_kind;
    pend_code_next = pend_code;
    push = 1'b0;
    rec  = '0;
    fin  = '0;
    dv   = '0;
    if (in_valid) begin
      if (in_type == REQ_TICK) begin
        if (state == ST_IDLE) begin
          state_next = ST_IDLE;
        end else if (gap_inc < limit) begin
          gap_count_next = gap_inc;
        end else begin
          gap_count_next = '0;
          state_next = ST_IDLE;
          lead_two_next = 1'b0;
          push = 1'b1;
          unique case (state)
            ST_PC:  rec.first = mk_char(CH_NUL);
            ST_ESC: rec.first = mk_char(CH_ESC);
            ST_SWALLOW: begin
              rec.first = pend_res;
              pend_kind_next = PK_NONE;
              pend_code_next = '0;
            end
            default: rec.first = mk_kind(KIND_BEEP);
          endcase
        end
      end else begin
        gap_count_next = '0;
        state_next = ST_IDLE;
        unique case (state)
          ST_PC: begin
            push = 1'b1;
            unique case (in_byte)
              8'h47: rec.first = mk_named(NK_HOME);
              8'h48: rec.first = mk_named(NK_UP);
              8'h49: rec.first = mk_named(NK_PGUP);
              8'h4f: rec.first = mk_named(NK_END);
              8'h50: rec.first = mk_named(NK_DOWN);
              8'h51: rec.first = mk_named(NK_PGDOWN);
              8'h4b, 8'h53: rec.first = mk_named(NK_LEFT);
              8'h4d: rec.first = mk_named(NK_RIGHT);
              8'h0f: rec.first = mk_named(NK_BKTAB);
              default: begin
                if (in_byte >= 8'h3b && in_byte <= 8'h43)
                  rec.first = mk_fkey(4'(in_byte - 8'h3a));
                else
                  rec.first = mk_kind(KIND_BEEP);
              end
            endcase
          end
          ST_ESC: begin
            if (in_byte == 8'h5b || in_byte == 8'h4f) begin
              state_next = ST_CSI;
            end else begin
              push = 1'b1;
              rec.two = 1'b1;
              rec.first = mk_char(CH_ESC);
              rec.second_char = in_byte;
            end
          end
          ST_CSI: begin
            if (in_byte >= 8'h50 && in_byte <= 8'h58) begin
              push = 1'b1;
              rec.first = mk_fkey(4'(in_byte - 8'h4f));
            end else if (in_byte == 8'h31 || in_byte == 8'h32) begin
              lead_two_next = (in_byte == 8'h32);
              state_next = ST_DIGIT;
            end else begin
              fin = body_final({1'b0, in_byte});
            end
          end
          ST_DIGIT: begin
            lead_two_next = 1'b0;
            if (lead_two)
              dv = {1'b0, in_byte} + 9'd9;
            else if (in_byte >= 8'h37)
              dv = {1'b0, in_byte} - 9'd1;
            else
              dv = {1'b0, in_byte};
            if (dv >= 9'h031 && dv <= 9'h039) begin
              fin.hold = 1'b1;
              fin.code = 4'(dv - 9'h030);
            end else begin
              fin = body_final(dv);
            end
            // digit form holds an fkey, body_final holds a named key
            if (fin.hold) begin
              state_next = ST_SWALLOW;
              pend_kind_next = (dv >= 9'h031 && dv <= 9'h039) ? PK_FKEY : PK_NAMED;
              pend_code_next = fin.code;
            end
          end
          ST_SWALLOW: begin
            push = 1'b1;
            rec.first = pend_res;
            pend_kind_next = PK_NONE;
            pend_code_next = '0;
          end
          default: begin
            push = 1'b1;
            unique case (in_byte)
              8'h03: rec.first = mk_kind(KIND_INTR);
              8'h0d: rec.first = mk_char(CH_LF);
              8'h0e: rec.first = mk_named(NK_DOWN);
              8'h08, 8'h7f: rec.first = mk_named(NK_LEFT);
              8'h0b, 8'h10: rec.first = mk_named(NK_UP);
              8'h0c: rec.first = mk_named(NK_RIGHT);
              8'h16: rec.first = mk_named(NK_PGDOWN);
              8'h00, 8'he0: begin push = 1'b0; state_next = ST_PC; end
              8'h1b: begin push = 1'b0; state_next = ST_ESC; end
              default: rec.first = mk_char(in_byte);
            endcase
          end
        endcase
        // CSI body final byte (digit form handled above)
        if (state == ST_CSI && !(in_byte >= 8'h50 && in_byte <= 8'h58) &&
            !(in_byte == 8'h31 || in_byte == 8'h32)) begin
          if (fin.hold) begin
            state_next = ST_SWALLOW;
            pend_kind_next = PK_NAMED;
            pend_code_next = fin.code;
          end else begin
            push = 1'b1;
            rec.first = fin.res;
          end
        end
        if (state == ST_DIGIT && !fin.hold) begin
          push = 1'b1;
          rec.first = fin.res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      state <= ST_IDLE;
      gap_count <= '0;
      lead_two <= 1'b0;
      pend_kind <= PK_NONE;
      pend_code <= '0;
      in_valid <= 1'b0;
    end else begin
      if (cfg_we)
        timeout_ticks <= cfg_data;
      state <= state_next;
      gap_count <= gap_count_next;
      lead_two <= lead_two_next;
      pend_kind <= pend_kind_next;
      pend_code <= pend_code_next;
      in_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // result queue
  assign head = q[rd_ptr];
  assign m_tvalid = (count != '0);
  assign pop = m_tvalid && m_tready && (!head.two || sub);

  always_ff @(posedge clk) begin
    if (push)
      q[wr_ptr] <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      sub <= 1'b0;
    end else begin
      if (push)
        wr_ptr <= wr_ptr + 2'd1;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
        sub <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        sub <= 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

  always_comb begin
    if (sub) begin
      m_tuser = KIND_CHAR;
      m_tdata = {8'h00, head.second_char};
      m_tlast = 1'b1;
    end else begin
      m_tuser = head.first.kind;
      m_tdata = {head.first.fkey_number, head.first.named_key, head.first.char_value};
      m_tlast = !head.two;
    end
  end

endmodule

// File: rtl/kesd_checker.sv
module kesd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import kesd_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result word changed while stalled");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result word right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= KIND_INTR)
    else $error("result kind out of range");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_CHAR |-> m_tdata[7:0] == 8'h00)
    else $error("char value set on non-char result");

  // a non-final word is the ESC of an ESC-other pair, followed by a final char
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> m_tuser == KIND_CHAR && m_tdata[7:0] == CH_ESC
      ##1 m_tvalid && m_tlast && m_tuser == KIND_CHAR)
    else $error("broken two-result run");

endmodule

bind key_escape_sequence_decoder kesd_checker u_kesd_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser),
  .m_tlast(m_tlast)
);

// File: tb/key_escape_sequence_decoder_tb.sv
`timescale 1ns / 100ps

module key_escape_sequence_decoder_tb;
  import kesd_pkg::*;

  // raw keyboard bytes that get special handling
  localparam logic [7:0] KEY_CTRL_C  = 8'h03;
  localparam logic [7:0] KEY_BS      = 8'h08;
  localparam logic [7:0] KEY_VT      = 8'h0b;
  localparam logic [7:0] KEY_FF      = 8'h0c;
  localparam logic [7:0] KEY_CR      = 8'h0d;
  localparam logic [7:0] KEY_SO      = 8'h0e;
  localparam logic [7:0] KEY_DLE     = 8'h10;
  localparam logic [7:0] KEY_SYN     = 8'h16;
  localparam logic [7:0] KEY_DEL     = 8'h7f;
  localparam logic [7:0] KEY_E0      = 8'he0;
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_SS3      = "O";
  localparam logic [7:0] CH_TILDE    = "~";

  // PC scan codes after a 0x00 / 0xE0 lead byte
  localparam logic [7:0] SC_BKTAB  = 8'h0f;
  localparam logic [7:0] SC_F1     = 8'h3b;
  localparam logic [7:0] SC_F9     = 8'h43;
  localparam logic [7:0] SC_HOME   = 8'h47;
  localparam logic [7:0] SC_UP     = 8'h48;
  localparam logic [7:0] SC_PGUP   = 8'h49;
  localparam logic [7:0] SC_LEFT   = 8'h4b;
  localparam logic [7:0] SC_RIGHT  = 8'h4d;
  localparam logic [7:0] SC_END    = 8'h4f;
  localparam logic [7:0] SC_DOWN   = 8'h50;
  localparam logic [7:0] SC_PGDOWN = 8'h51;
  localparam logic [7:0] SC_DEL    = 8'h53;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 4000;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [3:0] nk;
    logic [3:0] fk;
    logic       last;
  } key_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // key_byte
  logic        s_tuser = 1'b0;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // char_value[7:0], named_key[11:8], fkey_number[15:12]
  logic [2:0]  m_tuser;          // result_kind
  logic        m_tlast;          // last_of_run

  key_escape_sequence_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // decoder model state
  seq_state_t  kb_state = ST_IDLE;
  logic [15:0] gap_ticks = '0;
  logic        lead_two = 1'b0;
  logic [1:0]  held_kind = PK_NONE;
  logic [3:0]  held_code = '0;
  logic [15:0] timeout_ticks_m = TIMEOUT_RESET;

  key_word_t key_words_due[$];
  key_word_t run_words[$];
  int        words_decoded = 0;
  int        words_checked = 0;
  int        fail_count = 0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic void add_word(logic [2:0] k, logic [7:0] c, logic [3:0] n, logic [3:0] f);
    key_word_t w;
    w = '{kind: k, ch: c, nk: n, fk: f, last: 1'b0};
    run_words.push_back(w);
  endfunction

  function automatic void add_named(logic [3:0] n);
    add_word(KIND_NAMED, 8'd0, n, 4'd0);
  endfunction

  function automatic void add_beep();
    add_word(KIND_BEEP, 8'd0, 4'd0, 4'd0);
  endfunction

  function automatic void hold_key(logic [1:0] k, logic [3:0] code);
    held_kind = k;
    held_code = code;
    kb_state = ST_SWALLOW;
  endfunction

  function automatic void give_held();
    if (held_kind == PK_FKEY) add_word(KIND_FKEY, 8'd0, 4'd0, held_code);
    else add_named(held_code);
    held_kind = PK_NONE;
    held_code = '0;
  endfunction

  // final byte of an ANSI body; also reached from the digit form
  function automatic void decode_final(int v);
    case (v)
      CH_NUL: add_named(NK_END);
      "A": add_named(NK_UP);
      "B": add_named(NK_DOWN);
      "C": add_named(NK_RIGHT);
      "D": add_named(NK_LEFT);
      "6": hold_key(PK_NAMED, NK_PGDOWN);
      "3": hold_key(PK_NAMED, NK_PGUP);
      "2": hold_key(PK_NAMED, NK_HOME);
      "5": hold_key(PK_NAMED, NK_END);
      default: add_beep();
    endcase
  endfunction

  function automatic void decode_idle(logic [7:0] c);
    case (c)
      KEY_CTRL_C: add_word(KIND_INTR, 8'd0, 4'd0, 4'd0);
      KEY_CR: add_word(KIND_CHAR, CH_LF, 4'd0, 4'd0);
      KEY_SO: add_named(NK_DOWN);
      KEY_BS, KEY_DEL: add_named(NK_LEFT);
      KEY_VT, KEY_DLE: add_named(NK_UP);
      KEY_FF: add_named(NK_RIGHT);
      KEY_SYN: add_named(NK_PGDOWN);
      CH_NUL, KEY_E0: kb_state = ST_PC;
      CH_ESC: kb_state = ST_ESC;
      default: add_word(KIND_CHAR, c, 4'd0, 4'd0);
    endcase
  endfunction

  function automatic void decode_scan(logic [7:0] c);
    case (c)
      SC_HOME: add_named(NK_HOME);
      SC_UP: add_named(NK_UP);
      SC_PGUP: add_named(NK_PGUP);
      SC_END: add_named(NK_END);
      SC_DOWN: add_named(NK_DOWN);
      SC_PGDOWN: add_named(NK_PGDOWN);
      SC_LEFT, SC_DEL: add_named(NK_LEFT);
      SC_RIGHT: add_named(NK_RIGHT);
      SC_BKTAB: add_named(NK_BKTAB);
      default: begin
        if (c >= SC_F1 && c <= SC_F9) add_word(KIND_FKEY, 8'd0, 4'd0, 4'(c - SC_F1 + 1));
        else add_beep();
      end
    endcase
  endfunction

  function automatic void decode_byte(logic [7:0] c);
    seq_state_t was;
    int v;
    was = kb_state;
    gap_ticks = '0;
    kb_state = ST_IDLE;
    case (was)
      ST_PC: decode_scan(c);
      ST_ESC: begin
        if (c == CH_LBRACKET || c == CH_SS3) kb_state = ST_CSI;
        else begin
          add_word(KIND_CHAR, CH_ESC, 4'd0, 4'd0);
          add_word(KIND_CHAR, c, 4'd0, 4'd0);
        end
      end
      ST_CSI: begin
        if (c >= "P" && c <= "X") add_word(KIND_FKEY, 8'd0, 4'd0, 4'(c - "P" + 1));
        else if (c == "1" || c == "2") begin
          lead_two = (c == "2");
          kb_state = ST_DIGIT;
        end else decode_final(int'(c));
      end
      ST_DIGIT: begin
        // "2x" adds nine, so "20" maps onto F9; "1x" skips the gap after '6'
        v = int'(c);
        if (lead_two) v = v + 9;
        else if (v >= "7") v = v - 1;
        lead_two = 1'b0;
        if (v >= "1" && v <= "9") hold_key(PK_FKEY, 4'(v - "0"));
        else decode_final(v);
      end
      ST_SWALLOW: give_held();
      default: decode_idle(c);
    endcase
  endfunction

  function automatic void decode_tick();
    logic [15:0] limit;
    seq_state_t  was;
    limit = (timeout_ticks_m == 16'd0) ? 16'd1 : timeout_ticks_m;
    was = kb_state;
    if (was == ST_IDLE) return;
    if (gap_ticks != GAP_MAX) gap_ticks = gap_ticks + 16'd1;
    if (gap_ticks < limit) return;
    gap_ticks = '0;
    kb_state = ST_IDLE;
    lead_two = 1'b0;
    case (was)
      ST_PC: add_word(KIND_CHAR, CH_NUL, 4'd0, 4'd0);
      ST_ESC: add_word(KIND_CHAR, CH_ESC, 4'd0, 4'd0);
      ST_SWALLOW: give_held();
      default: add_beep();
    endcase
  endfunction

  function automatic void decode_key_item(logic req, logic [7:0] b);
    key_word_t w;
    if (req == REQ_TICK) begin
      if (kb_state != ST_IDLE) words_decoded++;
      decode_tick();
    end else begin
      words_decoded++;
      decode_byte(b);
    end
    while (run_words.size() != 0) begin
      w = run_words.pop_front();
      w.last = (run_words.size() == 0);
      key_words_due.push_back(w);
    end
  endfunction

  // input words feed the model, output words are checked against it
  always @(posedge clk) begin : track_words
    key_word_t want;
    if (rst) begin
      kb_state = ST_IDLE;
      gap_ticks = '0;
      lead_two = 1'b0;
      held_kind = PK_NONE;
      held_code = '0;
      key_words_due.delete();
    end else begin
      if (s_tvalid && s_tready) decode_key_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        words_checked++;
        if (key_words_due.size() == 0) begin
          $error("unexpected key word: result_kind %0d data %h", m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = key_words_due.pop_front();
          if (m_tuser !== want.kind) begin
            $error("result_kind expected %0d actual %0d", want.kind, m_tuser);
            fail_count++;
          end
          if (m_tdata[7:0] !== want.ch) begin
            $error("char_value expected %h actual %h", want.ch, m_tdata[7:0]);
            fail_count++;
          end
          if (m_tdata[11:8] !== want.nk) begin
            $error("named_key expected %0d actual %0d", want.nk, m_tdata[11:8]);
            fail_count++;
          end
          if (m_tdata[15:12] !== want.fk) begin
            $error("fkey_number expected %0d actual %0d", want.fk, m_tdata[15:12]);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_run expected %0d actual %0d", want.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // output ready: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic req, input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tuser <= 1'($urandom);
      s_tdata <= 8'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_key(input logic [7:0] b);
    send_word(REQ_BYTE, b);
  endtask

  task automatic send_tick();
    send_word(REQ_TICK, 8'($urandom));
  endtask

  // stop sending, wait for every due word, then let the decode stage settle
  task automatic wait_idle();
    int n;
    s_tvalid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < DRAIN_LIMIT && key_words_due.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_ticks_m = v;
  endtask

  task automatic test_directed_keys();
    send_idle_pct = 0;
    stall_pct = 0;
    send_key(KEY_CTRL_C);
    send_key(KEY_CR);
    send_key(8'hff);
    send_key(KEY_E0);
    send_key(SC_F1);
    send_key(CH_NUL);
    send_key(SC_F9);
    send_key(CH_ESC);           // ESC then a non-sequence byte: two words
    send_key("x");
    send_key(CH_ESC);
    send_key(CH_LBRACKET);
    send_key("A");
    send_key(CH_ESC);
    send_key(CH_SS3);
    send_key("X");
    send_key(CH_ESC);           // digit form, trailing '~' swallowed
    send_key(CH_LBRACKET);
    send_key("1");
    send_key("7");
    send_key(CH_TILDE);
    send_key(KEY_E0);           // PC lead byte times out after two ticks
    send_tick();
    send_tick();
    send_tick();                // idle tick, no word
    send_key(KEY_E0);
    send_key(CH_NUL);           // unknown scan code
  endtask

  task automatic test_gap_timeout();
    int k;
    set_timeout(16'd0);         // zero behaves as one
    send_key(CH_ESC);
    send_key(CH_LBRACKET);
    send_tick();
    set_timeout(16'd1);
    send_key(CH_ESC);
    send_key(CH_LBRACKET);
    send_key("2");
    send_tick();
    send_key(CH_ESC);
    send_key(CH_LBRACKET);
    send_key("6");
    send_tick();
    set_timeout(16'hffff);
    // a long limit keeps the sequence open across a run of ticks
    send_key(CH_ESC);
    for (k = 0; k < 20; k++) send_tick();
    send_key(CH_LBRACKET);
    send_key("A");
  endtask

  // one random key sequence, sometimes broken by inserted ticks that can time it out
  task automatic send_key_burst();
    logic [8:0] burst[$];
    logic [7:0] b;
    int pick;
    int n;
    int i;
    pick = $urandom_range(99);
    if (pick < 25) begin
      burst.push_back({REQ_BYTE, 8'($urandom)});
    end else if (pick < 40) begin
      burst.push_back({REQ_BYTE, ($urandom_range(1) != 0) ? KEY_E0 : CH_NUL});
      if ($urandom_range(3) != 0) b = 8'($urandom_range(SC_BKTAB, SC_DEL));
      else b = 8'($urandom);
      burst.push_back({REQ_BYTE, b});
    end else if (pick < 85) begin
      burst.push_back({REQ_BYTE, CH_ESC});
      if ($urandom_range(9) == 0) begin
        burst.push_back({REQ_BYTE, 8'($urandom)});
      end else begin
        burst.push_back({REQ_BYTE, ($urandom_range(1) != 0) ? CH_LBRACKET : CH_SS3});
        case ($urandom_range(5))
          0: begin
            case ($urandom_range(4))
              0: b = CH_NUL;
              1: b = "A";
              2: b = "B";
              3: b = "C";
              default: b = "D";
            endcase
            burst.push_back({REQ_BYTE, b});
          end
          1: burst.push_back({REQ_BYTE, 8'($urandom_range("P", "X"))});
          2: begin
            case ($urandom_range(2))
              0: b = "3";
              1: b = "5";
              default: b = "6";
            endcase
            burst.push_back({REQ_BYTE, b});
            burst.push_back({REQ_BYTE, ($urandom_range(3) != 0) ? CH_TILDE : 8'($urandom)});
          end
          3, 4: begin
            burst.push_back({REQ_BYTE, (pick[0]) ? 8'("1") : 8'("2")});
            if ($urandom_range(4) == 0) b = 8'($urandom);
            else if (pick[0]) b = 8'($urandom_range("1", ":"));
            else b = 8'($urandom_range(8'h26, 8'h32));
            burst.push_back({REQ_BYTE, b});
            burst.push_back({REQ_BYTE, ($urandom_range(3) != 0) ? CH_TILDE : 8'($urandom)});
          end
          default: burst.push_back({REQ_BYTE, 8'($urandom)});
        endcase
      end
    end else if (pick < 93) begin
      case ($urandom_range(8))
        0: b = KEY_CTRL_C;
        1: b = KEY_CR;
        2: b = KEY_SO;
        3: b = KEY_BS;
        4: b = KEY_DEL;
        5: b = KEY_VT;
        6: b = KEY_DLE;
        7: b = KEY_FF;
        default: b = KEY_SYN;
      endcase
      burst.push_back({REQ_BYTE, b});
    end else begin
      repeat ($urandom_range(1, 4)) burst.push_back({REQ_TICK, 8'($urandom)});
    end

    n = burst.size();
    if ($urandom_range(4) == 0) begin
      n = $urandom_range(1, burst.size());
      repeat ($urandom_range(0, 3)) burst.insert(n, {REQ_TICK, 8'($urandom)});
      n = burst.size();
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send_tick();
      send_word(burst[i][8], burst[i][7:0]);
    end
  endtask

  task automatic test_random_traffic(input int idle_in, input int stall_in,
                                     input logic [15:0] timeout, input int count);
    int target;
    set_timeout(timeout);
    send_idle_pct = idle_in;
    stall_pct = stall_in;
    target = words_decoded + count;
    while (words_decoded < target) send_key_burst();
  endtask

  // output held off while input keeps coming, so the result queue backs up
  task automatic test_output_backpressure();
    int k;
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    for (k = 0; k < 24; k++) begin
      send_key(CH_ESC);
      send_key(8'("a" + k));
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_keys();
    test_gap_timeout();
    test_random_traffic(0, 0, 16'd3, 210);
    test_random_traffic(56, 0, 16'd1, 210);
    test_random_traffic(0, 56, 16'($urandom_range(1, 6)), 210);
    test_random_traffic(7, 7, TIMEOUT_RESET, 210);
    test_output_backpressure();
    wait_idle();
    if (key_words_due.size() != 0)
      $error("%0d key words never arrived", key_words_due.size());
    $display("covered %0d decoded input words and %0d checked key words", words_decoded,
             words_checked);
    $display("timeouts 0, 1, 2, 3, 65535 and random; four idle mixes plus a long output hold");
    if (fail_count == 0 && key_words_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kesd_pkg.sv
rtl/key_escape_sequence_decoder.sv
rtl/kesd_checker.sv
tb/key_escape_sequence_decoder_tb.sv
